// ===== rtl/vkd_pkg.sv =====
// Shared types, sizes and helpers of the vertex key dedup core.
package vkd_pkg;

    // Key table and field sizes
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = 20;
    localparam int POS_W       = 20;
    localparam int ATTR_W      = 21;
    localparam int VNUM_W      = 10;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;

    // Hit tree: binary OR tree over the cells, registered every TREE_SPAN levels
    localparam int LEAVES          = 1 << ADDR_W;
    localparam int TREE_SPAN       = 4;
    localparam int TREE_REG_LEVELS = ADDR_W / TREE_SPAN;
    localparam int TREE_LAT        = 1 + TREE_REG_LEVELS;
    localparam int WAIT_W          = $clog2(TREE_LAT + 1);

    // Configuration register map
    localparam int PADDR_W  = 3;
    localparam int REGIDX_W = PADDR_W - 2;
    localparam logic [REGIDX_W-1:0] REG_BYPASS = REGIDX_W'(0);

    typedef struct packed {
        logic [IDX_W-1:0] pos;
        logic             tex_absent;
        logic [IDX_W-1:0] tex;
        logic             nrm_absent;
        logic [IDX_W-1:0] nrm;
    } key_t;

    typedef struct packed {
        logic clear;
        logic insert;
    } cell_ctrl_t;

    typedef struct packed {
        logic              any;
        logic [ADDR_W-1:0] idx;
    } hit_t;

    function automatic key_t make_key(
        input logic [POS_W-1:0]  pos,
        input logic [ATTR_W-1:0] tex,
        input logic [ATTR_W-1:0] nrm
    );
        key_t k;
        k.pos        = pos[IDX_W-1:0];
        k.tex_absent = tex[ATTR_W-1];
        k.tex        = tex[ATTR_W-1] ? '0 : tex[IDX_W-1:0];
        k.nrm_absent = nrm[ATTR_W-1];
        k.nrm        = nrm[ATTR_W-1] ? '0 : nrm[IDX_W-1:0];
        return k;
    endfunction

    // At most one cell hits, so OR merges the slot numbers
    function automatic hit_t merge_hit(input hit_t a, input hit_t b);
        hit_t m;
        m.any = a.any | b.any;
        m.idx = a.idx | b.idx;
        return m;
    endfunction

endpackage

// ===== rtl/vkd_cell.sv =====
// One table cell: stored key, valid flag and registered compare against the query.
module vkd_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  vkd_pkg::cell_ctrl_t ctrl,
    input  vkd_pkg::key_t      query,
    input  logic               prev_valid,
    output logic               valid,
    output logic               hit
);
    import vkd_pkg::*;

    logic valid_reg;
    logic hit_reg;
    key_t key_reg;
    logic take;

    // Free slot at the head of the empty run takes the new key
    assign take = ctrl.insert && prev_valid && !valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            key_reg <= query;
        end
        hit_reg <= valid_reg && (key_reg == query);
    end

    assign valid = valid_reg;
    assign hit   = hit_reg;

endmodule

// ===== rtl/vkd_hit_tree.sv =====
// Pipelined OR tree that turns the row of cell hits into a slot number.
module vkd_hit_tree (
    input  logic                            clk,
    input  logic [vkd_pkg::TABLE_DEPTH-1:0] hit,
    output vkd_pkg::hit_t                   root
);
    import vkd_pkg::*;

    hit_t node [1:2*LEAVES-1];

    for (genvar n = 1; n < 2 * LEAVES; n++)
    begin : g_node
        if (n >= LEAVES)
        begin : g_leaf
            if (n - LEAVES < TABLE_DEPTH)
            begin : g_used
                always_comb
                begin
                    node[n].any = hit[n-LEAVES];
                    node[n].idx = hit[n-LEAVES] ? ADDR_W'(n - LEAVES) : '0;
                end
            end
            else
            begin : g_pad
                always_comb
                begin
                    node[n] = '0;
                end
            end
        end
        else
        begin : g_inner
            localparam int LVL = $clog2(n + 1) - 1;
            if ((ADDR_W - LVL) % TREE_SPAN == 0)
            begin : g_reg
                always_ff @(posedge clk)
                begin
                    node[n] <= merge_hit(node[2*n], node[2*n+1]);
                end
            end
            else
            begin : g_comb
                always_comb
                begin
                    node[n] = merge_hit(node[2*n], node[2*n+1]);
                end
            end
        end
    end

    assign root = node[1];

endmodule

// ===== rtl/vertex_key_dedup_core.sv =====
// Top level of the vertex key dedup core: control, config port, cell row and hit tree.
//
//  channel   | signals                                             | beat taken when
//  ----------+-----------------------------------------------------+--------------------------
//  corner in | start, busy, position_index, texture_index,         | start && !busy
//            | normal_index, first_of_model                        |
//  result    | result_valid, vertex_number, is_new, table_full     | result_valid (one cycle)
//  config    | psel, penable, pwrite, paddr, pwdata, prdata, pready| psel && penable && pwrite
//
//  Each corner beat runs through IDLE (accept), PREP and SEARCH, where the core waits for the
//  compare to pass through the registered hit tree before it decides.
//  In bypass mode a beat ends after PREP. The result strobe rises in the cycle busy falls.
//  Reset empties the table and clears bypass; the stored keys themselves are not reset.
//  The receiver cannot stall: each result is shown for exactly one cycle.
module vertex_key_dedup_core (
    input  logic                        clk,
    input  logic                        rst_n,
    // corner input
    input  logic                        start,
    output logic                        busy,
    input  logic [vkd_pkg::POS_W-1:0]   position_index,
    input  logic signed [vkd_pkg::ATTR_W-1:0] texture_index,
    input  logic signed [vkd_pkg::ATTR_W-1:0] normal_index,
    input  logic                        first_of_model,
    // result output
    output logic                        result_valid,
    output logic [vkd_pkg::VNUM_W-1:0]  vertex_number,
    output logic                        is_new,
    output logic                        table_full,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vkd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import vkd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_SEARCH
    } state_t;

    state_t            state_reg, state_next;
    key_t              query_reg, query_next;
    logic              fom_reg, fom_next;
    logic              bypass_reg, bypass_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic              rvalid_reg, rvalid_next;
    logic [VNUM_W-1:0] vnum_reg, vnum_next;
    logic              new_reg, new_next;
    logic              full_reg, full_next;
    logic              cfg_bypass_reg, cfg_bypass_next;

    cell_ctrl_t             cell_ctrl;
    logic                   cell_valid [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_hit;
    hit_t                   root;

    logic                   accept;
    logic                   decide;
    logic                   is_full;
    logic                   cfg_write;
    logic [REGIDX_W-1:0]    reg_idx;

    // ------------------------------------------------------------------
    // Configuration port: pready held high, one bypass bit at word 0
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_bypass_next = cfg_bypass_reg;
        if (cfg_write && (reg_idx == REG_BYPASS))
        begin
            cfg_bypass_next = pwdata[0];
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_BYPASS: prdata = {31'd0, cfg_bypass_reg};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Row of cells. Valid flags fill from cell 0 upwards, so each cell
    // looks at its left neighbour to find the first free slot.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic prev_valid;
        if (i == 0)
        begin : g_head
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_valid = cell_valid[i-1];
        end

        vkd_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .query      (query_reg),
            .prev_valid (prev_valid),
            .valid      (cell_valid[i]),
            .hit        (cell_hit[i])
        );
    end

    // Reduce the hit row to one slot number over TREE_LAT - 1 registered levels
    vkd_hit_tree u_tree (
        .clk  (clk),
        .hit  (cell_hit),
        .root (root)
    );

    // ------------------------------------------------------------------
    // Sequencer
    //   IDLE   : take a corner beat, capture its key and the bypass bit
    //   PREP   : clear the table on first_of_model; finish bypass beats
    //   SEARCH : let the compare run through the tree, then decide
    // ------------------------------------------------------------------
    assign accept  = start && (state_reg == ST_IDLE);
    assign decide  = (state_reg == ST_SEARCH) && (wait_reg == WAIT_W'(TREE_LAT));
    assign is_full = (count_reg == CNT_W'(TABLE_DEPTH));

    always_comb
    begin
        cell_ctrl.clear  = (state_reg == ST_PREP) && fom_reg;
        cell_ctrl.insert = decide && !root.any && !is_full;
    end

    always_comb
    begin
        state_next  = state_reg;
        query_next  = query_reg;
        fom_next    = fom_reg;
        bypass_next = bypass_reg;
        count_next  = count_reg;
        wait_next   = wait_reg;
        rvalid_next = 1'b0;
        vnum_next   = vnum_reg;
        new_next    = new_reg;
        full_next   = full_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    query_next  = make_key(position_index, texture_index, normal_index);
                    fom_next    = first_of_model;
                    bypass_next = cfg_bypass_reg;
                    vnum_next   = position_index[VNUM_W-1:0];
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (fom_reg)
                begin
                    count_next = '0;
                end
                if (bypass_reg)
                begin
                    // Hand the low bits of the position index straight back
                    rvalid_next = 1'b1;
                    new_next    = 1'b0;
                    full_next   = 1'b0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    wait_next  = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                wait_next = wait_reg + WAIT_W'(1);
                if (decide)
                begin
                    rvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                    if (root.any)
                    begin
                        vnum_next = VNUM_W'(root.idx);
                        new_next  = 1'b0;
                        full_next = 1'b0;
                    end
                    else if (is_full)
                    begin
                        // Drop the key: no room left
                        vnum_next = '0;
                        new_next  = 1'b0;
                        full_next = 1'b1;
                    end
                    else
                    begin
                        vnum_next  = VNUM_W'(count_reg);
                        new_next   = 1'b1;
                        full_next  = 1'b0;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            wait_reg       <= '0;
            rvalid_reg     <= 1'b0;
            vnum_reg       <= '0;
            new_reg        <= 1'b0;
            full_reg       <= 1'b0;
            cfg_bypass_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            wait_reg       <= wait_next;
            rvalid_reg     <= rvalid_next;
            vnum_reg       <= vnum_next;
            new_reg        <= new_next;
            full_reg       <= full_next;
            cfg_bypass_reg <= cfg_bypass_next;
        end
    end

    // Payload holds need no reset
    always_ff @(posedge clk)
    begin
        query_reg  <= query_next;
        fom_reg    <= fom_next;
        bypass_reg <= bypass_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result_valid  = rvalid_reg;
    assign vertex_number = vnum_reg;
    assign is_new        = new_reg;
    assign table_full    = full_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_new_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(is_new && table_full))
        else $error("is_new and table_full both set");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_fill_match: assert property (@(posedge clk) disable iff (!rst_n)
        is_full == cell_valid[TABLE_DEPTH-1])
        else $error("fill count disagrees with cell row");

    a_new_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && is_new) |-> (vertex_number == VNUM_W'(count_reg - CNT_W'(1))))
        else $error("new key slot is not the last filled one");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !result_valid))
        else $error("beat taken but core not busy");

endmodule
